### rtl/cilc_pkg.sv
package cilc_pkg;

    // Event kinds carried by an input item.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_EVAL  = 2'd1;
    localparam logic [1:0] KIND_FLASH = 2'd2;

    // Lock sensor codes.
    localparam logic [1:0] SENSOR_LOCKED   = 2'd1;
    localparam logic [1:0] SENSOR_UNLOCKED = 2'd2;

    // State codes.
    localparam logic [3:0] ST_POWER_ON       = 4'd0;
    localparam logic [3:0] ST_IDLE           = 4'd1;
    localparam logic [3:0] ST_ONE_SIGNAL     = 4'd2;
    localparam logic [3:0] ST_LOCKING        = 4'd3;
    localparam logic [3:0] ST_LOCKED         = 4'd4;
    localparam logic [3:0] ST_CHARGING       = 4'd5;
    localparam logic [3:0] ST_NO_POWER       = 4'd6;
    localparam logic [3:0] ST_UNLOCKING      = 4'd7;
    localparam logic [3:0] ST_UNLOCKED       = 4'd8;
    localparam logic [3:0] ST_UNLOCK_FAILING = 4'd9;
    localparam logic [3:0] ST_UNLOCK_FAILED  = 4'd10;
    localparam logic [3:0] ST_NONE           = 4'd15;

    // Transition slots, in priority order.
    localparam int unsigned NUM_COND = 7;

    localparam logic [7:0] TIMEOUT_RESET = 8'd6;
    localparam logic [7:0] ELAPSED_MAX   = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic       pilot_valid;
        logic       proximity_valid;
        logic       unlock_pressed;
        logic [1:0] lock_sensor;
    } t_cilc_in;

    typedef struct packed {
        logic [3:0] current_state;
        logic       state_changed;
        logic       traction_inhibit;
        logic       pilot_pulldown;
        logic       lock_close;
        logic       lock_open;
        logic       led_red;
        logic       led_yellow;
        logic       led_green;
    } t_cilc_out;

    typedef logic [NUM_COND-1:0][3:0] t_next;

    typedef struct packed {
        t_next next;
        logic  inhibit;
        logic  close;
        logic  open;
        logic  pull;
        logic  red;
        logic  yellow;
        logic  green;
        logic  flash;
    } t_row;

    function automatic t_next mk_next(
        input logic [3:0] sw, input logic [3:0] none, input logic [3:0] one,
        input logic [3:0] both, input logic [3:0] lk, input logic [3:0] ul,
        input logic [3:0] to
    );
        return {to, ul, lk, both, one, none, sw};
    endfunction

    // Transition targets, drives and lamp pattern of each state.
    function automatic t_row row_of(input logic [3:0] mode);
        t_row r;
        r = '{next: mk_next(ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE),
              default: 1'b0};
        case (mode)
            ST_POWER_ON: begin
                r.next = mk_next(ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE,
                                 ST_IDLE);
                r.open = 1'b1;
                r.red = 1'b1; r.yellow = 1'b1; r.green = 1'b1;
            end
            ST_IDLE: begin
                r.next = mk_next(ST_NONE, ST_NONE, ST_ONE_SIGNAL, ST_LOCKING, ST_NONE,
                                 ST_NONE, ST_NONE);
            end
            ST_ONE_SIGNAL: begin
                r.next = mk_next(ST_NONE, ST_NONE, ST_NONE, ST_LOCKING, ST_NONE, ST_NONE,
                                 ST_NONE);
                r.inhibit = 1'b1;
                r.yellow = 1'b1;
            end
            ST_LOCKING: begin
                r.next = mk_next(ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE,
                                 ST_LOCKED);
                r.inhibit = 1'b1; r.close = 1'b1;
                r.yellow = 1'b1; r.flash = 1'b1;
            end
            ST_LOCKED: begin
                r.next = mk_next(ST_UNLOCKING, ST_NONE, ST_NONE, ST_NONE, ST_CHARGING,
                                 ST_UNLOCK_FAILING, ST_NONE);
                r.inhibit = 1'b1;
                r.yellow = 1'b1; r.flash = 1'b1;
            end
            ST_CHARGING: begin
                r.next = mk_next(ST_UNLOCKING, ST_NO_POWER, ST_NO_POWER, ST_NONE, ST_NONE,
                                 ST_NONE, ST_NONE);
                r.inhibit = 1'b1; r.pull = 1'b1;
                r.green = 1'b1;
            end
            ST_NO_POWER: begin
                r.next = mk_next(ST_UNLOCKING, ST_NONE, ST_NONE, ST_CHARGING, ST_NONE,
                                 ST_NONE, ST_NONE);
                r.inhibit = 1'b1;
                r.red = 1'b1; r.flash = 1'b1;
            end
            ST_UNLOCKING: begin
                r.next = mk_next(ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE,
                                 ST_UNLOCKED);
                r.inhibit = 1'b1; r.open = 1'b1;
                r.yellow = 1'b1; r.flash = 1'b1;
            end
            ST_UNLOCKED: begin
                r.next = mk_next(ST_UNLOCKING, ST_IDLE, ST_NONE, ST_NONE, ST_NONE, ST_NONE,
                                 ST_NONE);
                r.inhibit = 1'b1;
                r.yellow = 1'b1;
            end
            ST_UNLOCK_FAILING: begin
                r.next = mk_next(ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE,
                                 ST_UNLOCK_FAILED);
                r.inhibit = 1'b1; r.open = 1'b1;
                r.red = 1'b1; r.flash = 1'b1;
            end
            ST_UNLOCK_FAILED: begin
                r.next = mk_next(ST_UNLOCKING, ST_IDLE, ST_NONE, ST_NONE, ST_NONE, ST_NONE,
                                 ST_NONE);
                r.inhibit = 1'b1;
                r.red = 1'b1; r.flash = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/cilc_in_if.sv
interface cilc_in_if;
    logic               valid;
    logic               ready;
    cilc_pkg::t_cilc_in data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/cilc_out_if.sv
interface cilc_out_if;
    logic                valid;
    logic                ready;
    cilc_pkg::t_cilc_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/cilc_cfg_if.sv
interface cilc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/charge_inlet_lock_controller.sv
// Charging inlet lock controller.
//
// Items arrive on i_in (valid/ready). Each item is one event: a decisecond
// tick, an evaluate event carrying the pilot, proximity, unlock switch and
// lock sensor readings, or a flash toggle. Every item yields exactly one
// result item on o_out, showing the state after the event, whether it
// changed, the drives and the lamps after the flash phase.
// The motor timeout register is written through i_cfg, which is always
// ready; writes are only expected while no item is in flight.
// An accepted item lands in the input register, and
// the state update plus the table lookup sit between that register and the
// result register. Throughput is one item per cycle while o_out.ready holds;
// a receiver stall holds back the result register and then the input register.
// Reset (synchronous, active low) puts the block in the power-on state with
// the timer at zero, lamps lit and the motor timeout at 6 deciseconds.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item, after which i_in.ready drops.
module charge_inlet_lock_controller (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cilc_in_if.sink   i_in,
    cilc_cfg_if.sink  i_cfg,
    cilc_out_if.source o_out
);
    import cilc_pkg::*;

    logic       r_in_valid;
    t_cilc_in   r_in;
    logic       r_out_valid;
    t_cilc_out  r_out;

    logic [7:0] r_motor_timeout;
    logic [3:0] r_mode;
    logic [7:0] r_elapsed;
    logic       r_flash;

    logic [3:0] n_mode;
    logic [7:0] n_elapsed;
    logic       n_flash;
    logic       n_changed;
    t_cilc_out  n_out;

    logic       advance;
    logic       found;
    t_row       cur_row;
    t_row       new_row;
    logic [NUM_COND-1:0] cond;

    // The result stage moves whenever its register is empty or being drained.
    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign cur_row = row_of(r_mode);

    // Transition conditions in priority order.
    always_comb begin
        cond[0] = r_in.unlock_pressed;
        cond[1] = !r_in.pilot_valid && !r_in.proximity_valid;
        cond[2] = r_in.pilot_valid != r_in.proximity_valid;
        cond[3] = r_in.pilot_valid && r_in.proximity_valid;
        cond[4] = r_in.lock_sensor == SENSOR_LOCKED;
        cond[5] = r_in.lock_sensor == SENSOR_UNLOCKED;
        cond[6] = r_elapsed >= r_motor_timeout;
    end

    always_comb begin
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        n_flash   = r_flash;
        n_changed = 1'b0;
        found     = 1'b0;
        case (r_in.kind)
            KIND_TICK: begin
                if (r_elapsed != ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 8'd1;
                end
            end
            KIND_FLASH: begin
                if (cur_row.flash) begin
                    n_flash = !r_flash;
                end
            end
            KIND_EVAL: begin
                // The first existing transition whose condition holds wins.
                for (int i = 0; i < NUM_COND; i++) begin
                    if (!found && cur_row.next[i] != ST_NONE && cond[i]) begin
                        found     = 1'b1;
                        n_mode    = cur_row.next[i];
                        n_elapsed = '0;
                        n_flash   = 1'b1;
                        n_changed = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign new_row = row_of(n_mode);

    always_comb begin
        n_out.current_state    = n_mode;
        n_out.state_changed    = n_changed;
        n_out.traction_inhibit = new_row.inhibit;
        n_out.pilot_pulldown   = new_row.pull;
        n_out.lock_close       = new_row.close;
        n_out.lock_open        = new_row.open;
        // Flashing patterns go dark in the off phase.
        n_out.led_red    = new_row.red && (!new_row.flash || n_flash);
        n_out.led_yellow = new_row.yellow && (!new_row.flash || n_flash);
        n_out.led_green  = new_row.green && (!new_row.flash || n_flash);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_motor_timeout <= TIMEOUT_RESET;
            r_mode          <= ST_POWER_ON;
            r_elapsed       <= '0;
            r_flash         <= 1'b1;
        end else begin
            if (i_cfg.valid) begin
                r_motor_timeout <= i_cfg.data;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_mode    <= n_mode;
                    r_elapsed <= n_elapsed;
                    r_flash   <= n_flash;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

### dv/tb.sv
module tb;
    import cilc_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [1:0] SENSOR_OTHER = 2'd0;
    localparam logic [1:0] SENSOR_SPARE = 2'd3;

    // Length of the long receiver hold, in cycles.
    localparam int LONG_HOLD = 300;

    // Transition slots of a state, in the order the controller tests them.
    typedef enum int {
        SLOT_SWITCH,
        SLOT_NEITHER,
        SLOT_ONE,
        SLOT_BOTH,
        SLOT_LOCKED,
        SLOT_UNLOCKED,
        SLOT_TIMEOUT
    } t_slot;

    // One line of the directed script: either a timeout register write or an
    // event item, optionally with its result spelled out by hand.
    typedef struct {
        bit         cfg;
        logic [7:0] value;
        t_cilc_in   ev;
        bit         typed;
        t_cilc_out  want;
    } t_step;

    // One random phase: timeout setting, idling on each side and item count.
    typedef struct {
        logic [7:0] timeout;
        int         src_idle;
        int         sink_stall;
        int         count;
        bit         squeeze;
    } t_phase;

    localparam t_cilc_out NO_WANT = '0;
    localparam t_cilc_out AT_POWER_ON = '{current_state: ST_POWER_ON, lock_open: 1'b1,
                                          led_red: 1'b1, led_yellow: 1'b1, led_green: 1'b1,
                                          default: 1'b0};
    localparam t_cilc_out INTO_IDLE = '{current_state: ST_IDLE, state_changed: 1'b1,
                                        default: 1'b0};

    logic i_clk;
    logic i_rst_n;

    cilc_in_if  in_if ();
    cilc_cfg_if cfg_if ();
    cilc_out_if out_if ();

    charge_inlet_lock_controller uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    // Predicted controller state, kept in step with every accepted item.
    logic [3:0] mdl_state;
    logic [7:0] mdl_elapsed;
    logic       mdl_lit;
    logic [7:0] mdl_timeout;

    // Results that the block still owes, oldest first.
    t_cilc_out lock_status_q[$];

    int         errors;
    int         n_events;
    int         n_results;
    int         n_moves;
    logic [15:0] states_seen;

    int src_idle_pct;
    int sink_stall_pct;

    // The main process bumps hold_req; the receiver process notices the change
    // and counts the hold down on its own.
    int hold_req;
    int hold_seen;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Next state for a given slot, or ST_NONE where the state has no such
    // transition. Unknown state codes have no transitions at all.
    function automatic logic [3:0] route(input logic [3:0] s, input t_slot slot);
        case (s)
            ST_POWER_ON: begin
                if (slot == SLOT_TIMEOUT) return ST_IDLE;
            end
            ST_IDLE: begin
                if (slot == SLOT_ONE) return ST_ONE_SIGNAL;
                if (slot == SLOT_BOTH) return ST_LOCKING;
            end
            ST_ONE_SIGNAL: begin
                if (slot == SLOT_BOTH) return ST_LOCKING;
            end
            ST_LOCKING: begin
                if (slot == SLOT_TIMEOUT) return ST_LOCKED;
            end
            ST_LOCKED: begin
                if (slot == SLOT_SWITCH) return ST_UNLOCKING;
                if (slot == SLOT_LOCKED) return ST_CHARGING;
                if (slot == SLOT_UNLOCKED) return ST_UNLOCK_FAILING;
            end
            ST_CHARGING: begin
                if (slot == SLOT_SWITCH) return ST_UNLOCKING;
                if (slot == SLOT_NEITHER || slot == SLOT_ONE) return ST_NO_POWER;
            end
            ST_NO_POWER: begin
                if (slot == SLOT_SWITCH) return ST_UNLOCKING;
                if (slot == SLOT_BOTH) return ST_CHARGING;
            end
            ST_UNLOCKING: begin
                if (slot == SLOT_TIMEOUT) return ST_UNLOCKED;
            end
            ST_UNLOCKED, ST_UNLOCK_FAILED: begin
                if (slot == SLOT_SWITCH) return ST_UNLOCKING;
                if (slot == SLOT_NEITHER) return ST_IDLE;
            end
            ST_UNLOCK_FAILING: begin
                if (slot == SLOT_TIMEOUT) return ST_UNLOCK_FAILED;
            end
            default: begin
            end
        endcase
        return ST_NONE;
    endfunction

    function automatic bit flashes(input logic [3:0] s);
        return s inside {ST_LOCKING, ST_LOCKED, ST_NO_POWER, ST_UNLOCKING,
                         ST_UNLOCK_FAILING, ST_UNLOCK_FAILED};
    endfunction

    // Drives and lamps of a state; flashing lamps go dark in the off phase.
    function automatic t_cilc_out drives_of(input logic [3:0] s, input logic lit);
        t_cilc_out o;
        o = '0;
        o.current_state = s;
        // Drive order: inhibit, pulldown, close, open. Lamp order: red, yellow, green.
        case (s)
            ST_POWER_ON: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b0001;
                {o.led_red, o.led_yellow, o.led_green} = 3'b111;
            end
            ST_ONE_SIGNAL, ST_LOCKED, ST_UNLOCKED: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b1000;
                {o.led_red, o.led_yellow, o.led_green} = 3'b010;
            end
            ST_LOCKING: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b1010;
                {o.led_red, o.led_yellow, o.led_green} = 3'b010;
            end
            ST_CHARGING: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b1100;
                {o.led_red, o.led_yellow, o.led_green} = 3'b001;
            end
            ST_NO_POWER, ST_UNLOCK_FAILED: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b1000;
                {o.led_red, o.led_yellow, o.led_green} = 3'b100;
            end
            ST_UNLOCKING: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b1001;
                {o.led_red, o.led_yellow, o.led_green} = 3'b010;
            end
            ST_UNLOCK_FAILING: begin
                {o.traction_inhibit, o.pilot_pulldown, o.lock_close, o.lock_open} = 4'b1001;
                {o.led_red, o.led_yellow, o.led_green} = 3'b100;
            end
            default: begin
            end
        endcase
        if (flashes(s) && !lit) begin
            {o.led_red, o.led_yellow, o.led_green} = 3'b000;
        end
        return o;
    endfunction

    // Applies one event to the predicted state and returns the status the
    // block must report for it.
    function automatic t_cilc_out next_lock_status(input t_cilc_in ev);
        t_cilc_out               st;
        logic                    moved;
        logic [3:0]              target;
        logic [NUM_COND-1:0]     hit;
        int                      k;
        moved = 1'b0;
        case (ev.kind)
            KIND_TICK: begin
                if (mdl_elapsed != ELAPSED_MAX) mdl_elapsed = mdl_elapsed + 8'd1;
            end
            KIND_FLASH: begin
                if (flashes(mdl_state)) mdl_lit = !mdl_lit;
            end
            KIND_EVAL: begin
                hit[SLOT_SWITCH]   = ev.unlock_pressed;
                hit[SLOT_NEITHER]  = !ev.pilot_valid && !ev.proximity_valid;
                hit[SLOT_ONE]      = ev.pilot_valid != ev.proximity_valid;
                hit[SLOT_BOTH]     = ev.pilot_valid && ev.proximity_valid;
                hit[SLOT_LOCKED]   = ev.lock_sensor == SENSOR_LOCKED;
                hit[SLOT_UNLOCKED] = ev.lock_sensor == SENSOR_UNLOCKED;
                hit[SLOT_TIMEOUT]  = mdl_elapsed >= mdl_timeout;
                // The first slot that exists for the state and holds wins.
                for (k = 0; k < NUM_COND; k++) begin
                    target = route(mdl_state, t_slot'(k));
                    if (!moved && target != ST_NONE && hit[k]) begin
                        mdl_state   = target;
                        mdl_elapsed = '0;
                        mdl_lit     = 1'b1;
                        moved       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        st = drives_of(mdl_state, mdl_lit);
        st.state_changed = moved;
        return st;
    endfunction

    function automatic t_cilc_in random_event();
        t_cilc_in e;
        int       roll;
        roll = $urandom_range(99);
        if (roll < 50) begin
            e.kind = KIND_EVAL;
        end else if (roll < 83) begin
            e.kind = KIND_TICK;
        end else if (roll < 95) begin
            e.kind = KIND_FLASH;
        end else begin
            e.kind = KIND_UNUSED;
        end
        e.pilot_valid     = 1'($urandom_range(1));
        e.proximity_valid = 1'($urandom_range(1));
        e.unlock_pressed  = 1'($urandom_range(1));
        e.lock_sensor     = 2'($urandom_range(3));
        return e;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("result %0d %s got %0d want %0d", n_results, name,
                                    got, want));
        end
    endtask

    // Offers one item, with random gaps before it, and records its expected
    // result once the block takes it. Called and returns at a falling edge.
    task automatic send_event(input t_cilc_in ev, input bit typed, input t_cilc_out want);
        t_cilc_out predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= ev;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = next_lock_status(ev);
        // Hand-written rows replace the prediction; the model state still advances.
        lock_status_q.push_back(typed ? want : predicted);
        n_events++;
        if (predicted.state_changed) n_moves++;
        states_seen[predicted.current_state] = 1'b1;
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every result is back.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (lock_status_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_timeout(input logic [7:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        mdl_timeout = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Result checker: every accepted result is matched against the oldest
    // pending expectation, field by field.
    always @(posedge i_clk) begin
        t_cilc_out want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            n_results++;
            if (lock_status_q.size() == 0) begin
                note_mismatch($sformatf("result %0d with nothing pending: %p", n_results,
                                        out_if.data));
            end else begin
                want = lock_status_q.pop_front();
                check_field("current_state", out_if.data.current_state, want.current_state);
                check_field("state_changed", 4'(out_if.data.state_changed),
                            4'(want.state_changed));
                check_field("traction_inhibit", 4'(out_if.data.traction_inhibit),
                            4'(want.traction_inhibit));
                check_field("pilot_pulldown", 4'(out_if.data.pilot_pulldown),
                            4'(want.pilot_pulldown));
                check_field("lock_close", 4'(out_if.data.lock_close), 4'(want.lock_close));
                check_field("lock_open", 4'(out_if.data.lock_open), 4'(want.lock_open));
                check_field("led_red", 4'(out_if.data.led_red), 4'(want.led_red));
                check_field("led_yellow", 4'(out_if.data.led_yellow), 4'(want.led_yellow));
                check_field("led_green", 4'(out_if.data.led_green), 4'(want.led_green));
            end
        end
    end

    // Receiver: random stalls at the phase's rate, or a long hold on request.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

    // Directed script. It starts at power-on with the reset timeout, pokes the
    // ignored cases there, then drops the timeout to zero so that each motor
    // state leaves on its first evaluate, and walks the whole lock cycle,
    // including the failed unlock path and a flash toggle in a flashing state.
    t_step script[25] = '{
        '{1'b0, 8'd0, '{KIND_TICK, 1'b0, 1'b0, 1'b0, SENSOR_OTHER}, 1'b1, AT_POWER_ON},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b1, SENSOR_SPARE}, 1'b1, AT_POWER_ON},
        '{1'b0, 8'd0, '{KIND_UNUSED, 1'b1, 1'b1, 1'b1, SENSOR_SPARE}, 1'b1, AT_POWER_ON},
        '{1'b0, 8'd0, '{KIND_FLASH, 1'b0, 1'b0, 1'b0, SENSOR_OTHER}, 1'b1, AT_POWER_ON},
        '{1'b1, 8'd0, '0, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b0, 1'b0, 1'b0, SENSOR_OTHER}, 1'b1, INTO_IDLE},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b0, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_UNLOCKED}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_FLASH, 1'b0, 1'b0, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_LOCKED}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b0, 1'b0, 1'b0, SENSOR_LOCKED}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b1, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b0, 1'b0, 1'b0, SENSOR_UNLOCKED}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_UNLOCKED}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b1, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_FLASH, 1'b1, 1'b1, 1'b1, SENSOR_SPARE}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b0, 1'b1, 1'b1, SENSOR_LOCKED}, 1'b0, NO_WANT},
        '{1'b1, 8'd255, '0, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_TICK, 1'b1, 1'b0, 1'b1, SENSOR_UNLOCKED}, 1'b0, NO_WANT},
        '{1'b0, 8'd0, '{KIND_EVAL, 1'b1, 1'b0, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT}
    };

    // Random phases. The idling mix covers none, sender only, receiver only
    // and both; the timeout goes through small values and both extremes.
    t_phase plan[6] = '{
        '{8'd6,   0,  0,  170, 1'b0},
        '{8'd0,   49, 0,  170, 1'b0},
        '{8'd3,   0,  49, 170, 1'b0},
        '{8'd255, 18, 18, 170, 1'b0},
        '{8'd1,   0,  0,  170, 1'b1},
        '{8'd2,   18, 18, 170, 1'b0}
    };

    initial begin
        logic [7:0] timeout;
        int         p;
        int         n;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data      = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        errors          = 0;
        n_events        = 0;
        n_results       = 0;
        n_moves         = 0;
        states_seen     = '0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_req        = 0;
        hold_seen       = 0;
        hold_left       = 0;
        // Reset state of the controller as the predictor sees it.
        mdl_state       = ST_POWER_ON;
        mdl_elapsed     = '0;
        mdl_lit         = 1'b1;
        mdl_timeout     = TIMEOUT_RESET;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            if (script[i].cfg) begin
                settle();
                load_timeout(script[i].value);
            end else begin
                send_event(script[i].ev, script[i].typed, script[i].want);
            end
        end

        for (p = 0; p < 6; p++) begin
            // The register only changes while nothing is in flight.
            settle();
            timeout = plan[p].timeout;
            if (p == 5) timeout = 8'($urandom_range(12));
            load_timeout(timeout);
            src_idle_pct   = plan[p].src_idle;
            sink_stall_pct = plan[p].sink_stall;
            // At the top timeout only a saturated timer can ever expire, so
            // run the timer into saturation before the random mix.
            if (timeout == ELAPSED_MAX) begin
                for (n = 0; n < 260; n++) begin
                    send_event('{KIND_TICK, 1'(n), 1'(n >> 1), 1'(n >> 2), 2'(n >> 3)},
                               1'b0, NO_WANT);
                end
                send_event('{KIND_EVAL, 1'b1, 1'b0, 1'b0, SENSOR_OTHER}, 1'b0, NO_WANT);
            end
            for (n = 0; n < plan[p].count; n++) begin
                // Halfway through the pressure phase the receiver holds off
                // for a long stretch while items keep coming, so the input
                // register and the result register both fill and the block
                // must drop its ready.
                if (plan[p].squeeze && n == plan[p].count / 2) hold_req++;
                send_event(random_event(), 1'b0, NO_WANT);
            end
        end

        settle();
        repeat (6) @(negedge i_clk);

        $display("tb: %0d events sent, %0d results checked, %0d state changes, %0d of 11 states",
                 n_events, n_results, n_moves, $countones(states_seen));
        $display("tb: timeouts 0 to 255, timer saturation, four idling mixes, one long hold");
        if (errors == 0 && lock_status_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/cilc_pkg.sv
rtl/cilc_in_if.sv
rtl/cilc_out_if.sv
rtl/cilc_cfg_if.sv
rtl/charge_inlet_lock_controller.sv
dv/tb.sv
